>>> rtl/ilp_pkg.sv
package ilp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int LIMIT_W    = 33;
  localparam int NXT_W      = VALUE_BITS + 5;
  localparam int CMP_W      = (VALUE_BITS + 2 > LIMIT_W + 1) ? VALUE_BITS + 2 : LIMIT_W + 1;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;

  localparam logic [4:0] DIGIT_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIGN,
    PH_ZERO,
    PH_NEED,
    PH_DIGS
  } phase_e;

  typedef enum logic [1:0] {
    RDX_BIN,
    RDX_OCT,
    RDX_DEC,
    RDX_HEX
  } radix_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_MISSING,
    ST_OVERFLOW,
    ST_RANGE
  } status_e;

  typedef enum logic [1:0] {
    CFG_SIGNED_MODE,
    CFG_MAX_LIMIT,
    CFG_MIN_LIMIT
  } cfg_idx_e;

  typedef struct packed {
    logic               signed_mode;
    logic [LIMIT_W-1:0] max_limit;
    logic [LIMIT_W-1:0] min_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       start_req;
  } item_t;

  // Digit value of a character, DIGIT_NONE when it is no hex digit at all.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = 5'(c - CH_LC_A) + 5'd10;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = 5'(c - CH_UC_A) + 5'd10;
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_val(input radix_e r);
    logic [4:0] v;
    case (r)
      RDX_BIN: v = 5'd2;
      RDX_OCT: v = 5'd8;
      RDX_DEC: v = 5'd10;
      default: v = 5'd16;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ilp_if.sv
interface ilp_in_if import ilp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_req;

  modport source (output valid, output char_code, output start_req, input ready);
  modport sink   (input valid, input char_code, input start_req, output ready);
endinterface

interface ilp_out_if import ilp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

interface ilp_cfg_if import ilp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         index;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ilp_cfg.sv
module ilp_cfg import ilp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  logic [1:0]         wr_index_i,
  input  logic [LIMIT_W-1:0] wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_mode <= 1'b0;
      cfg_q.max_limit   <= {1'b0, {(LIMIT_W-1){1'b1}}};
      cfg_q.min_limit   <= '0;
    end else if (wr_valid_i) begin
      // Writes to an index beyond the register list are dropped.
      unique case (wr_index_i)
        CFG_SIGNED_MODE: cfg_q.signed_mode <= wr_data_i[0];
        CFG_MAX_LIMIT:   cfg_q.max_limit   <= wr_data_i;
        CFG_MIN_LIMIT:   cfg_q.min_limit   <= wr_data_i;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ilp_in_reg.sv
module ilp_in_reg import ilp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  advance_i
);

  logic  valid_q;
  item_t item_q;

  // A held character leaves in the same cycle the next one is taken.
  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

>>> rtl/ilp_parse.sv
module ilp_parse import ilp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               advance_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [LIMIT_W-1:0] res_value_o,
  output logic [1:0]         res_status_o
);

  localparam logic [NXT_W-1:0] LIM_U  = {5'b0, {VALUE_BITS{1'b1}}};
  localparam logic [NXT_W-1:0] LIM_SP = {6'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [NXT_W-1:0] LIM_SN = {5'b0, 1'b1, {(VALUE_BITS-1){1'b0}}};

  phase_e                phase_q, phase_d;
  radix_e                radix_q, radix_d;
  logic                  negative_q, negative_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;

  logic                  res_valid_q;
  logic [LIMIT_W-1:0]    res_value_q;
  status_e               res_status_q;

  logic [7:0]            c;
  logic [4:0]            digit;
  radix_e                acc_radix;
  logic [VALUE_BITS-1:0] acc_mag;
  logic                  in_radix;
  logic [NXT_W-1:0]      mag_ext;
  logic [NXT_W-1:0]      nxt;
  logic [NXT_W-1:0]      lim;
  logic                  ovf;
  logic                  fin_neg;
  logic signed [CMP_W-1:0] sval;
  logic signed [CMP_W-1:0] max_ext;
  logic signed [CMP_W-1:0] min_ext;
  logic                  range_err;

  logic                  emit;
  status_e               emit_status;
  logic [LIMIT_W-1:0]    emit_value;

  assign advance_o    = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o  = res_valid_q;
  assign res_value_o  = res_value_q;
  assign res_status_o = res_status_q;

  assign c     = item_i.char_code;
  assign digit = digit_of(c);

  // After a lone zero the literal becomes octal and starts from nothing.
  assign acc_radix = (phase_q == PH_ZERO) ? RDX_OCT : radix_q;
  assign acc_mag   = (phase_q == PH_ZERO) ? '0 : mag_q;
  assign in_radix  = digit < radix_val(acc_radix);

  // Magnitude times radix plus digit, built from shifts.
  assign mag_ext = NXT_W'(acc_mag);
  always_comb begin
    case (acc_radix)
      RDX_BIN: nxt = (mag_ext << 1);
      RDX_OCT: nxt = (mag_ext << 3);
      RDX_DEC: nxt = (mag_ext << 3) + (mag_ext << 1);
      default: nxt = (mag_ext << 4);
    endcase
    nxt = nxt + NXT_W'(digit[3:0]);
  end

  assign lim = cfg_i.signed_mode ? (negative_q ? LIM_SN : LIM_SP) : LIM_U;
  assign ovf = nxt > lim;

  // The sign only counts in signed mode, and minus zero is zero.
  assign fin_neg = negative_q && cfg_i.signed_mode && (acc_mag != '0);
  assign sval    = fin_neg ? -$signed(CMP_W'(acc_mag)) : $signed(CMP_W'(acc_mag));
  assign max_ext = $signed({{(CMP_W-LIMIT_W){cfg_i.max_limit[LIMIT_W-1]}}, cfg_i.max_limit});
  assign min_ext = $signed({{(CMP_W-LIMIT_W){cfg_i.min_limit[LIMIT_W-1]}}, cfg_i.min_limit});
  assign range_err = (sval > max_ext) || (sval < min_ext);

  always_comb begin
    phase_d     = phase_q;
    radix_d     = radix_q;
    negative_d  = negative_q;
    mag_d       = mag_q;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;

    if (item_i.start_req || phase_q == PH_SIGN) begin
      if (item_i.start_req) begin
        negative_d = 1'b0;
        mag_d      = '0;
        radix_d    = RDX_BIN;
      end
      if (c == CH_MINUS && item_i.start_req && cfg_i.signed_mode) begin
        negative_d = 1'b1;
        phase_d    = PH_SIGN;
      end else if (c == CH_ZERO) begin
        phase_d = PH_ZERO;
      end else if (c >= CH_ONE && c <= CH_NINE) begin
        radix_d = RDX_DEC;
        mag_d   = VALUE_BITS'(digit[3:0]);
        phase_d = PH_DIGS;
      end else begin
        emit        = 1'b1;
        emit_status = ST_MISSING;
      end
    end else begin
      unique case (phase_q)
        PH_ZERO, PH_DIGS, PH_NEED: begin
          if (phase_q == PH_ZERO && c == CH_LC_B) begin
            radix_d = RDX_BIN;
            phase_d = PH_NEED;
          end else if (phase_q == PH_ZERO && c == CH_LC_X) begin
            radix_d = RDX_HEX;
            phase_d = PH_NEED;
          end else begin
            radix_d = acc_radix;
            mag_d   = acc_mag;
            phase_d = PH_DIGS;
            if (in_radix) begin
              if (ovf) begin
                emit        = 1'b1;
                emit_status = ST_OVERFLOW;
              end else begin
                mag_d = nxt[VALUE_BITS-1:0];
              end
            end else if (phase_q == PH_NEED) begin
              emit        = 1'b1;
              emit_status = ST_MISSING;
            end else if (range_err) begin
              emit        = 1'b1;
              emit_status = ST_RANGE;
            end else begin
              emit        = 1'b1;
              emit_status = ST_OK;
              emit_value  = sval[LIMIT_W-1:0];
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    if (emit) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      radix_q    <= RDX_BIN;
      negative_q <= 1'b0;
      mag_q      <= '0;
    end else if (advance_o) begin
      phase_q    <= phase_d;
      radix_q    <= radix_d;
      negative_q <= negative_d;
      mag_q      <= mag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance_o && emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && emit) begin
      res_value_q  <= emit_value;
      res_status_q <= emit_status;
    end
  end

endmodule

>>> rtl/integer_literal_parser_unit.sv
// Integer literal parser: takes one ASCII character per cycle and, on the character that
// ends a literal, gives one result with the value (33-bit two's complement, zero on error)
// and a status (ok, missing digits, overflow, out of range). A character is registered on
// input and its parse step (one shift-and-add of the magnitude, a limit compare and the
// phase update) runs from that input register into the result register, which holds the
// result until it is taken; a new character is taken every cycle as long as the result
// register drains. Configuration is taken at any time on its own channel, but must only
// be changed while no literal is in flight.
module integer_literal_parser_unit import ilp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilp_in_if.sink     in_i,
  ilp_out_if.source  out_o,
  ilp_cfg_if.sink    cfg_i
);

  cfg_t  cfg;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;

  assign in_item.char_code = in_i.char_code;
  assign in_item.start_req = in_i.start_req;

  ilp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  ilp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .advance_i    (advance)
  );

  ilp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_value_o  (out_o.value),
    .res_status_o (out_o.status)
  );

endmodule

>>> verif/literal_checker.sv
`timescale 1ns / 1ps
module literal_checker import ilp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ilp_in_if    chars,
  ilp_out_if   results,
  ilp_cfg_if   regs,
  output int   fail_cnt,
  output int   pending_cnt
);

  typedef struct packed {
    logic [LIMIT_W-1:0] value;
    status_e            status;
  } literal_result_t;

  literal_result_t expected_q[$];

  // Register copies as seen by the parser.
  bit     signed_on;
  longint max_lim;
  longint min_lim;

  // Parser state.
  phase_e          phase;
  radix_e          radix;
  bit              minus_seen;
  longint unsigned mag;

  function automatic int unsigned digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LC_A && c <= CH_LC_F) return c - CH_LC_A + 10;
    if (c >= CH_UC_A && c <= CH_UC_F) return c - CH_UC_A + 10;
    return 16;
  endfunction

  function automatic int unsigned radix_base(input radix_e r);
    case (r)
      RDX_BIN: return 2;
      RDX_OCT: return 8;
      RDX_DEC: return 10;
      default: return 16;
    endcase
  endfunction

  // Ends the literal. The value field is only meaningful on success.
  function automatic bit settle(input status_e s, input longint v,
                                output logic [LIMIT_W-1:0] val, output status_e st);
    val   = (s == ST_OK) ? v[LIMIT_W-1:0] : '0;
    st    = s;
    phase = PH_IDLE;
    return 1'b1;
  endfunction

  // Overflow is flagged on the first digit that would leave the type range.
  function automatic bit add_digit(input int unsigned d,
                                   output logic [LIMIT_W-1:0] val, output status_e st);
    longint unsigned ceiling;
    longint unsigned base;
    base = radix_base(radix);
    if (!signed_on) begin
      ceiling = {64{1'b1}} >> (64 - VALUE_BITS);
    end else if (minus_seen) begin
      ceiling = ({64{1'b1}} >> (65 - VALUE_BITS)) + 1;
    end else begin
      ceiling = {64{1'b1}} >> (65 - VALUE_BITS);
    end
    if (mag > (ceiling - d) / base) return settle(ST_OVERFLOW, 0, val, st);
    mag = mag * base + d;
    return 1'b0;
  endfunction

  // The sign only counts if signed mode is still on when the literal ends.
  function automatic bit close_literal(output logic [LIMIT_W-1:0] val, output status_e st);
    bit     neg;
    longint v;
    neg = minus_seen && signed_on && mag != 0;
    v   = neg ? -longint'(mag) : longint'(mag);
    if (v > max_lim || v < min_lim) return settle(ST_RANGE, 0, val, st);
    return settle(ST_OK, v, val, st);
  endfunction

  function automatic bit lead_char(input logic [7:0] c, input bit allow_minus,
                                   output logic [LIMIT_W-1:0] val, output status_e st);
    if (c == CH_MINUS && allow_minus && signed_on) begin
      minus_seen = 1'b1;
      phase      = PH_SIGN;
      return 1'b0;
    end
    if (c == CH_ZERO) begin
      phase = PH_ZERO;
      return 1'b0;
    end
    if (c >= CH_ONE && c <= CH_NINE) begin
      radix = RDX_DEC;
      mag   = c - CH_ZERO;
      phase = PH_DIGS;
      return 1'b0;
    end
    return settle(ST_MISSING, 0, val, st);
  endfunction

  function automatic bit step_char(input logic [7:0] c, input logic start,
                                   output logic [LIMIT_W-1:0] val, output status_e st);
    int unsigned d;
    d   = digit_value(c);
    val = '0;
    st  = ST_OK;
    if (start) begin
      minus_seen = 1'b0;
      mag        = 0;
      radix      = RDX_BIN;
      return lead_char(c, 1'b1, val, st);
    end
    case (phase)
      PH_SIGN: return lead_char(c, 1'b0, val, st);
      PH_ZERO: begin
        if (c == CH_LC_B) begin
          radix = RDX_BIN;
          phase = PH_NEED;
          return 1'b0;
        end
        if (c == CH_LC_X) begin
          radix = RDX_HEX;
          phase = PH_NEED;
          return 1'b0;
        end
        radix = RDX_OCT;
        mag   = 0;
        phase = PH_DIGS;
        if (d < 8) return add_digit(d, val, st);
        return close_literal(val, st);
      end
      PH_NEED: begin
        if (d < radix_base(radix)) begin
          phase = PH_DIGS;
          return add_digit(d, val, st);
        end
        return settle(ST_MISSING, 0, val, st);
      end
      PH_DIGS: begin
        if (d < radix_base(radix)) return add_digit(d, val, st);
        return close_literal(val, st);
      end
      default: begin
        phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // Results are popped before new characters are predicted: a result never
  // leaves the block in the cycle its character is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    literal_result_t    exp_res;
    logic [LIMIT_W-1:0] val;
    status_e            st;
    if (!rst_ni) begin
      signed_on   = 1'b0;
      max_lim     = 64'sd4294967295;
      min_lim     = 0;
      phase       = PH_IDLE;
      radix       = RDX_BIN;
      minus_seen  = 1'b0;
      mag         = 0;
      expected_q.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
    end else begin
      if (regs.valid && regs.ready) begin
        case (cfg_idx_e'(regs.index))
          CFG_SIGNED_MODE: signed_on = regs.data[0];
          CFG_MAX_LIMIT:   max_lim = longint'($signed(regs.data));
          CFG_MIN_LIMIT:   min_lim = longint'($signed(regs.data));
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: value %0d, status %0d",
                 $signed(results.value), results.status);
          fail_cnt++;
        end else begin
          exp_res = expected_q.pop_front();
          if (results.value !== exp_res.value) begin
            $error("value: expected %0d, got %0d",
                   $signed(exp_res.value), $signed(results.value));
            fail_cnt++;
          end
          if (results.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, results.status);
            fail_cnt++;
          end
        end
      end
      if (chars.valid && chars.ready) begin
        if (step_char(chars.char_code, chars.start_req, val, st)) begin
          exp_res.value  = val;
          exp_res.status = st;
          expected_q.push_back(exp_res);
        end
      end
      pending_cnt = expected_q.size();
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import ilp_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 210;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int     fail_cnt;
  int     pending_cnt;
  int     idle_cycles = 0;
  int     sent_cnt    = 0;
  bit     hold_out    = 1'b0;
  bit     calm        = 1'b0;
  bit     cur_signed;
  longint cur_max;
  longint cur_min;

  // Characters of the literal being built: {start_req, char_code}.
  logic [8:0] seq_q[$];

  ilp_in_if  in_if ();
  ilp_out_if out_if ();
  ilp_cfg_if cfg_if ();

  integer_literal_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  literal_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chars       (in_if),
    .results     (out_if),
    .regs        (cfg_if),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: short random stalls, long ready stretches now and then, and
  // one long hold-off on request.
  initial begin
    int hi;
    int lo;
    out_if.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
      end else begin
        hi = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 16);
        out_if.ready <= 1'b1;
        repeat (hi) @(posedge clk_i);
        lo = pick_gap();
        if (lo > 0) begin
          out_if.ready <= 1'b0;
          repeat (lo) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input bit start);
    int gap;
    gap = (hold_out || calm) ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.start_req <= start;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == 0);
    end
  endtask

  task automatic set_config(input bit sm, input longint maxv, input longint minv);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_SIGNED_MODE;
    cfg_if.data  <= LIMIT_W'(sm);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.index <= CFG_MAX_LIMIT;
    cfg_if.data  <= maxv[LIMIT_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.index <= CFG_MIN_LIMIT;
    cfg_if.data  <= minv[LIMIT_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_signed = sm;
    cur_max    = maxv;
    cur_min    = minv;
  endtask

  // A start on a character that cannot open a literal leaves the parser idle,
  // so the registers may be changed once its result is back.
  task automatic close_phase();
    send_char(" ", 1'b1);
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic void put(input logic [7:0] c, input bit start);
    seq_q.push_back({start, c});
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return 8'(CH_ZERO + d);
    if ($urandom_range(0, 1)) return 8'(CH_LC_A + d - 10);
    return 8'(CH_UC_A + d - 10);
  endfunction

  function automatic logic [7:0] end_char(input int unsigned base);
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(128, 255));
      1: begin
        case ($urandom_range(0, 3))
          0: return ",";
          1: return ";";
          2: return ")";
          default: return 8'h0A;
        endcase
      end
      2: return (base == 2) ? "2" : (base == 8) ? "9" : (base == 10) ? "a" : "g";
      default: return " ";
    endcase
  endfunction

  // Magnitudes cluster around the type bounds and the programmed limits.
  function automatic longint unsigned pick_magnitude();
    longint bound;
    int     delta;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 20);
      3: return $urandom_range(0, 1000);
      4, 5: return {32'd0, $urandom()};
      6: begin
        case ($urandom_range(0, 5))
          0: return 64'h7FFF_FFFF;
          1: return 64'h8000_0000;
          2: return 64'h8000_0001;
          3: return 64'hFFFF_FFFF;
          4: return 64'h1_0000_0000;
          default: return 64'h1_0000_0001;
        endcase
      end
      7: begin
        bound = $urandom_range(0, 1) ? cur_max : cur_min;
        if (bound < 0) bound = -bound;
        delta = $urandom_range(0, 2);
        bound = bound + delta - 1;
        return (bound < 0) ? 0 : bound;
      end
      8: return {24'd0, 8'($urandom_range(1, 255)), $urandom()};
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic longint rand_limit();
    int unsigned u;
    int          s;
    u = $urandom_range(0, 1000);
    s = $urandom_range(0, 2000);
    case ($urandom_range(0, 3))
      0: return -64'sd2147483648 + longint'(u);
      1: return longint'($urandom());
      2: return s - 1000;
      default: return 64'sd4294967295 - longint'(u);
    endcase
  endfunction

  task automatic build_literal();
    int              kind;
    int unsigned     base;
    longint unsigned m;
    logic [7:0]      digits[$];
    bit              lead;
    kind = $urandom_range(0, 99);
    lead = 1'b1;
    if (kind < 10) begin
      // Noise: random bytes with random start flags.
      repeat ($urandom_range(1, 3)) begin
        put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end else if (kind < 22) begin
      case ($urandom_range(0, 2))
        0: begin
          put(CH_ZERO, 1'b1);
          case ($urandom_range(0, 3))
            0: put(CH_LC_B, 1'b0);
            1: put(CH_LC_X, 1'b0);
            2: put("B", 1'b0);
            default: put("X", 1'b0);
          endcase
          put(8'($urandom_range(0, 255)), 1'b0);
        end
        1: begin
          put(CH_MINUS, 1'b1);
          put(CH_MINUS, 1'b0);
          put(" ", 1'b0);
        end
        default: begin
          put(CH_MINUS, 1'b1);
          put(8'($urandom_range(0, 255)), 1'b0);
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: base = 2;
        1: base = 8;
        2: base = 10;
        default: base = 16;
      endcase
      m = pick_magnitude();
      if ($urandom_range(0, 2) == 0 && (cur_signed || $urandom_range(0, 3) == 0)) begin
        put(CH_MINUS, lead);
        lead = 1'b0;
      end
      if (base != 10) begin
        put(CH_ZERO, lead);
        lead = 1'b0;
      end
      if (base == 2) put(CH_LC_B, 1'b0);
      if (base == 16) put(CH_LC_X, 1'b0);
      if (base != 10 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) put(CH_ZERO, 1'b0);
      end
      do begin
        digits.push_front(digit_char(m % base));
        m = m / base;
      end while (m != 0);
      foreach (digits[i]) begin
        put(digits[i], lead);
        lead = 1'b0;
      end
      // Now and then the literal is cut short and the next start drops it.
      if ($urandom_range(0, 9) == 0) begin
        while (seq_q.size() > 1 && $urandom_range(0, 1)) void'(seq_q.pop_back());
      end else begin
        put(end_char(base), 1'b0);
      end
    end
  endtask

  task automatic random_run(input int n);
    int         first_cnt;
    logic [8:0] entry;
    first_cnt = sent_cnt;
    while (sent_cnt - first_cnt < n) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      build_literal();
      while (seq_q.size() != 0) begin
        entry = seq_q.pop_front();
        send_char(entry[7:0], entry[8]);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.start_req = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    cur_signed      = 1'b0;
    cur_max         = 64'sd4294967295;
    cur_min         = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register reset values: unsigned, full range.
    send_char("x", 1'b0);
    send_text("0b1 ");
    send_text("0xF.");
    send_text("0b2");
    send_text("07:");
    send_text("0 ");
    send_text("-");
    send_text("9");
    send_text("5z");
    send_text("A");
    random_run(PHASE_ITEMS);
    close_phase();

    set_config(1'b1, 64'sd2147483647, -64'sd2147483648);
    send_text("--");
    send_text("-0 ");
    hold_out = 1'b1;
    random_run(PHASE_ITEMS);
    close_phase();

    set_config(1'b0, 64'sd4294967295, 0);
    random_run(PHASE_ITEMS);
    close_phase();

    set_config(1'b1, 1000, -1000);
    random_run(PHASE_ITEMS);
    close_phase();

    set_config(1'b0, 300, 17);
    random_run(PHASE_ITEMS);
    close_phase();

    set_config(1'b1, -5, -64'sd2147483648);
    random_run(PHASE_ITEMS);
    close_phase();

    set_config(1'b1, 64'sd4294967295, -64'sd2147483648);
    random_run(PHASE_ITEMS);
    close_phase();

    set_config(1'($urandom_range(0, 1)), rand_limit(), rand_limit());
    random_run(PHASE_ITEMS);
    close_phase();

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
